// ===== src/gpf_pkg.sv =====
// shared types and constants for the goldbach prime pair finder
package gpf_pkg;

    localparam int unsigned NUM_W   = 16;
    localparam int unsigned SMALL_W = 15;

    localparam logic [NUM_W-1:0] MIN_PAIR_SUM = 16'd6;
    localparam logic [NUM_W-1:0] FIRST_ODD    = 16'd3;
    localparam logic [NUM_W-1:0] ODD_STEP     = 16'd2;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             trivial;
    } t_job;

    typedef enum logic [2:0] {
        MP_CLEAR,
        MP_CHECK,
        MP_WAIT,
        MP_MARK,
        MP_READY
    } t_map_state;

    typedef enum logic {
        SC_IDLE,
        SC_SCAN
    } t_scan_state;

endpackage

// ===== src/goldbach_prime_pair_finder.sv =====
// top level of the goldbach prime pair finder
//
// input channel: i_valid / o_ready carry i_number; output channel: o_valid /
// i_ready carry o_found, o_small_prime and o_large_prime, one result per number
// after reset the block clears its composite bitmap (all LIMIT+1 entries, one entry
// a cycle) and then sieves it; o_ready stays low until the sieve is finished
// a number is classified on transfer and queued in a two-entry queue; the scan
// engine tests one odd candidate per cycle, reading the bitmap at i and n-i on
// two read ports; odd numbers and numbers below six skip the scan, and their
// no-pair result is written straight into the output register
// numbers are served one at a time by the scan engine; while the output
// register holds an untaken result the queue keeps accepting until full,
// and the scan engine waits before starting the next number
module goldbach_prime_pair_finder import gpf_pkg::*; #(
    parameter int unsigned LIMIT = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [NUM_W-1:0]   i_number,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic [SMALL_W-1:0] o_small_prime,
    output logic [NUM_W-1:0]   o_large_prime
);

    localparam int unsigned IDX_W = $clog2(LIMIT + 1);

    logic             w_table_ready;
    logic             w_job_valid;
    t_job             w_job;
    logic             w_pop;
    logic [IDX_W-1:0] w_addr_a, w_addr_b;
    logic             w_comp_a, w_comp_b;

    gpf_map #(
        .LIMIT (LIMIT),
        .IDX_W (IDX_W)
    ) u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_addr_a      (w_addr_a),
        .i_addr_b      (w_addr_b),
        .o_comp_a      (w_comp_a),
        .o_comp_b      (w_comp_b),
        .o_table_ready (w_table_ready)
    );

    gpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_number      (i_number),
        .i_table_ready (w_table_ready),
        .i_pop         (w_pop),
        .o_ready       (o_ready),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job)
    );

    gpf_scan #(
        .LIMIT (LIMIT),
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_pop         (w_pop),
        .o_addr_a      (w_addr_a),
        .o_addr_b      (w_addr_b),
        .i_comp_a      (w_comp_a),
        .i_comp_b      (w_comp_b),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_small_prime (o_small_prime),
        .o_large_prime (o_large_prime)
    );

    a_no_ready_before_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_table_ready |-> !o_ready)
        else $error("input ready before sieve complete");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_job_valid)
        else $error("queue popped while empty");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_small_prime == '0) && (o_large_prime == '0))
        else $error("no-pair result carries nonzero primes");

    a_pair_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (NUM_W'(o_small_prime) <= o_large_prime)
            && o_small_prime[0] && o_large_prime[0])
        else $error("found pair not odd or not ordered");

endmodule

// ===== src/gpf_map.sv =====
// composite bitmap memory with clearing pass and sieve controller
module gpf_map import gpf_pkg::*; #(
    parameter int unsigned LIMIT = 65535,
    parameter int unsigned IDX_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_addr_a,
    input  logic [IDX_W-1:0] i_addr_b,
    output logic             o_comp_a,
    output logic             o_comp_b,
    output logic             o_table_ready
);

    localparam int unsigned BASE_W = (IDX_W + 1) / 2 + 1;
    localparam int unsigned SQ_W   = IDX_W + 1;

    logic r_mem [0:LIMIT];
    logic r_rd_a, r_rd_b;

    t_map_state r_state, n_state;
    logic [IDX_W-1:0]  r_clr;
    logic [BASE_W-1:0] r_base;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_mult;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic             w_wdata;
    logic [IDX_W-1:0] w_raddr_a;
    logic             w_clr_last;
    logic             w_sq_over;
    logic             w_mult_over;
    logic             w_advance;

    assign w_clr_last  = (r_clr == IDX_W'(LIMIT));
    assign w_sq_over   = (r_sq > SQ_W'(LIMIT));
    assign w_mult_over = (r_mult > SQ_W'(LIMIT));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            MP_CLEAR: begin
                if (w_clr_last) begin
                    n_state = MP_CHECK;
                end
            end
            MP_CHECK: begin
                n_state = w_sq_over ? MP_READY : MP_WAIT;
            end
            MP_WAIT: begin
                n_state = r_rd_a ? MP_CHECK : MP_MARK;
            end
            MP_MARK: begin
                if (w_mult_over) begin
                    n_state = MP_CHECK;
                end
            end
            MP_READY: begin
                n_state = MP_READY;
            end
            default: begin
                n_state = MP_CLEAR;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        w_we          = 1'b0;
        w_waddr       = r_clr;
        w_wdata       = 1'b0;
        w_advance     = 1'b0;
        w_raddr_a     = IDX_W'(r_base);
        o_table_ready = 1'b0;
        case (r_state)
            MP_CLEAR: begin
                w_we = 1'b1;
            end
            MP_CHECK: begin
            end
            MP_WAIT: begin
                w_advance = r_rd_a;
            end
            MP_MARK: begin
                w_we      = !w_mult_over;
                w_waddr   = r_mult[IDX_W-1:0];
                w_wdata   = 1'b1;
                w_advance = w_mult_over;
            end
            MP_READY: begin
                w_raddr_a     = i_addr_a;
                o_table_ready = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MP_CLEAR;
            r_clr   <= '0;
            r_base  <= BASE_W'(2);
            r_sq    <= SQ_W'(4);
        end else begin
            r_state <= n_state;
            if (r_state == MP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_advance) begin
                r_base <= r_base + 1'b1;
                r_sq   <= r_sq + SQ_W'({r_base, 1'b1});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MP_WAIT) begin
            r_mult <= r_sq;
        end else if (r_state == MP_MARK) begin
            r_mult <= r_mult + SQ_W'(r_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[i_addr_b];
    end

    assign o_comp_a = r_rd_a;
    assign o_comp_b = r_rd_b;

endmodule

// ===== src/gpf_front.sv =====
// input acceptance, classification and two-entry job queue
module gpf_front import gpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_number,
    input  logic             i_table_ready,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_job_valid,
    output t_job             o_job
);

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push;
    t_job       w_job;

    assign o_ready     = i_table_ready && (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // odd numbers and numbers below six have no odd prime pair
    assign w_job.number  = i_number;
    assign w_job.trivial = i_number[0] || (i_number < MIN_PAIR_SUM);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule

// ===== src/gpf_scan.sv =====
// candidate scan engine with pipelined bitmap reads and output register
module gpf_scan import gpf_pkg::*; #(
    parameter int unsigned LIMIT = 65535,
    parameter int unsigned IDX_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_pop,
    output logic [IDX_W-1:0]   o_addr_a,
    output logic [IDX_W-1:0]   o_addr_b,
    input  logic               i_comp_a,
    input  logic               i_comp_b,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_found,
    output logic [SMALL_W-1:0] o_small_prime,
    output logic [NUM_W-1:0]   o_large_prime
);

    localparam int unsigned EXT_W = (IDX_W > NUM_W) ? IDX_W : NUM_W;

    t_scan_state r_state, n_state;

    logic [NUM_W-1:0]   r_n;
    logic [NUM_W-1:0]   r_i;
    logic [SMALL_W-1:0] r_ci;
    logic               r_pend;
    logic               r_rng;
    logic               r_ovalid;
    logic               r_found;
    logic [SMALL_W-1:0] r_small;
    logic [NUM_W-1:0]   r_large;

    logic [NUM_W-1:0] w_vb;
    logic [EXT_W-1:0] w_ext_a, w_ext_b;
    logic             w_rng;
    logic             w_issue;
    logic             w_hit;
    logic             w_finish;
    logic             w_start;

    assign w_vb     = r_n - r_i;
    assign w_ext_a  = EXT_W'(r_i);
    assign w_ext_b  = EXT_W'(w_vb);
    assign w_rng    = (w_ext_a <= EXT_W'(LIMIT)) && (w_ext_b <= EXT_W'(LIMIT));
    assign o_addr_a = w_ext_a[IDX_W-1:0];
    assign o_addr_b = w_ext_b[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: begin
                if (w_start && !i_job.trivial) begin
                    n_state = SC_SCAN;
                end
            end
            SC_SCAN: begin
                if (w_finish) begin
                    n_state = SC_IDLE;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        w_start  = 1'b0;
        w_issue  = 1'b0;
        w_hit    = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            SC_IDLE: begin
                w_start = i_job_valid && !r_ovalid;
            end
            SC_SCAN: begin
                w_issue  = (r_i <= {1'b0, r_n[NUM_W-1:1]});
                w_hit    = r_pend && r_rng && !i_comp_a && !i_comp_b;
                w_finish = w_hit || !w_issue;
            end
            default: begin
            end
        endcase
    end

    assign o_pop = w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SC_IDLE;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_pend <= 1'b0;
            end else if (r_state == SC_SCAN) begin
                r_pend <= w_issue && !w_finish;
            end
            if ((w_start && i_job.trivial) || w_finish) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_n     <= i_job.number;
            r_i     <= FIRST_ODD;
            r_found <= 1'b0;
            r_small <= '0;
            r_large <= '0;
        end else if (r_state == SC_SCAN) begin
            if (w_issue) begin
                r_i  <= r_i + ODD_STEP;
                r_ci <= r_i[SMALL_W-1:0];
                r_rng <= w_rng;
            end
            if (w_hit) begin
                r_found <= 1'b1;
                r_small <= r_ci;
                r_large <= r_n - NUM_W'(r_ci);
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_found       = r_found;
    assign o_small_prime = r_small;
    assign o_large_prime = r_large;

endmodule

// ===== verif/goldbach_pair_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the goldbach prime pair finder: predicts every split and compares results
module goldbach_pair_checker import gpf_pkg::*; #(
    parameter int unsigned LIMIT = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [NUM_W-1:0]   i_number,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic               o_found,
    input  logic [SMALL_W-1:0] o_small_prime,
    input  logic [NUM_W-1:0]   o_large_prime,
    input  logic               i_drain_done,
    output int                 o_error_count,
    output int                 o_pending,
    output int                 o_results_seen,
    output int                 o_pairs_seen
);

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic               found;
        logic [SMALL_W-1:0] small_prime;
        logic [NUM_W-1:0]   large_prime;
    } t_split;

    bit     prime_flag [0:65535];
    t_split pending_splits [$];
    bit     leftovers_flushed;

    function automatic bit prime_at(input int unsigned idx);
        if (idx > LIMIT || idx > 65535)
            return 1'b0;
        return prime_flag[idx];
    endfunction

    function automatic t_split split_number(input logic [NUM_W-1:0] n);
        t_split      s;
        int unsigned half;
        int unsigned cand;
        s        = '0;
        s.number = n;
        half     = n / 2;
        cand     = 3;
        while (cand <= half && !s.found) begin
            if (prime_at(cand) && prime_at(int'(n) - cand)) begin
                s.found       = 1'b1;
                s.small_prime = SMALL_W'(cand);
                s.large_prime = NUM_W'(int'(n) - cand);
            end
            cand += 2;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $realtime, msg);
        o_error_count++;
    endtask

    initial begin : build_sieve
        int unsigned base;
        int unsigned mult;
        for (int k = 0; k < 65536; k++)
            prime_flag[k] = 1'b1;
        prime_flag[0] = 1'b0;
        prime_flag[1] = 1'b0;
        for (base = 2; base * base <= LIMIT; base++) begin
            if (prime_at(base)) begin
                for (mult = base * base; mult <= LIMIT && mult <= 65535; mult += base)
                    prime_flag[mult] = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_split want;
        if (i_rst_n) begin
            // result transfer first: it can never belong to a number taken at this edge
            if (o_valid && i_ready) begin
                o_results_seen++;
                if (o_found === 1'b1)
                    o_pairs_seen++;
                if (pending_splits.size() == 0) begin
                    report_mismatch($sformatf("result %0b/%0d/%0d with no number pending",
                                              o_found, o_small_prime, o_large_prime));
                end else begin
                    want = pending_splits.pop_front();
                    if (o_found !== want.found)
                        report_mismatch($sformatf("number %0d: found %0b, expected %0b",
                                                  want.number, o_found, want.found));
                    if (o_small_prime !== want.small_prime)
                        report_mismatch($sformatf("number %0d: small prime %0d, expected %0d",
                                                  want.number, o_small_prime,
                                                  want.small_prime));
                    if (o_large_prime !== want.large_prime)
                        report_mismatch($sformatf("number %0d: large prime %0d, expected %0d",
                                                  want.number, o_large_prime,
                                                  want.large_prime));
                end
            end
            if (i_valid && o_ready)
                pending_splits.push_back(split_number(i_number));
            if (i_drain_done && !leftovers_flushed) begin
                leftovers_flushed = 1'b1;
                while (pending_splits.size() != 0) begin
                    want = pending_splits.pop_front();
                    report_mismatch($sformatf("number %0d: no result arrived", want.number));
                end
            end
            o_pending <= pending_splits.size();
        end
    end

endmodule

// ===== verif/goldbach_prime_pair_finder_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the goldbach prime pair finder: stimulus, pacing and verdict
module goldbach_prime_pair_finder_tb;
    import gpf_pkg::*;

    localparam int unsigned LIMIT          = 65535;
    localparam int          RANDOM_NUMBERS = 850;
    localparam int          DRAIN_LIMIT    = 100000;
    localparam int          SETTLE_CYCLES  = 300;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKED,
        RX_PERIODIC
    } t_stall_mode;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic [NUM_W-1:0]   i_number = '0;
    logic               i_ready  = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_found;
    logic [SMALL_W-1:0] o_small_prime;
    logic [NUM_W-1:0]   o_large_prime;

    logic drain_done = 1'b0;
    int   error_count;
    int   pending_count;
    int   results_seen;
    int   pairs_seen;

    bit steady     = 1'b1;
    int burst_left = 0;

    // even numbers whose first odd pair sits unusually far out
    logic [NUM_W-1:0] late_pair_numbers [10] = '{
        16'd98, 16'd220, 16'd308, 16'd556, 16'd992,
        16'd2642, 16'd5372, 16'd7426, 16'd43532, 16'd54244
    };

    logic [NUM_W-1:0] edge_numbers [15] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd12,
        16'd32768, 16'd65534, 16'd65535, 16'd21845, 16'd43690
    };

    always #1 i_clk = ~i_clk;

    goldbach_prime_pair_finder #(
        .LIMIT(LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_small_prime(o_small_prime),
        .o_large_prime(o_large_prime)
    );

    goldbach_pair_checker #(
        .LIMIT(LIMIT)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_number      (i_number),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_small_prime (o_small_prime),
        .o_large_prime (o_large_prime),
        .i_drain_done  (drain_done),
        .o_error_count (error_count),
        .o_pending     (pending_count),
        .o_results_seen(results_seen),
        .o_pairs_seen  (pairs_seen)
    );

    task automatic send_number(input logic [NUM_W-1:0] n);
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_number <= n;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid  <= 1'b0;
            i_number <= NUM_W'($urandom);
        end
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!steady)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    function automatic logic [NUM_W-1:0] pick_number();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return NUM_W'($urandom_range(3, 32767) * 2);
        if (r < 70)
            return NUM_W'($urandom_range(0, 40));
        if (r < 80)
            return NUM_W'($urandom_range(0, 32767) * 2 + 1);
        if (r < 88)
            return late_pair_numbers[$urandom_range(0, 9)];
        return NUM_W'($urandom_range(0, 65535));
    endfunction

    initial begin : receiver
        t_stall_mode mode;
        int          span;
        int          tick;
        tick = 0;
        forever begin
            mode = steady ? RX_OPEN : t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_CHOKED: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    initial begin : stimulus
        int drain_wait;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first numbers are offered while the sieve is still being built
        foreach (edge_numbers[k]) begin
            send_number(edge_numbers[k]);
            pace_sender();
        end
        foreach (late_pair_numbers[k]) begin
            send_number(late_pair_numbers[k]);
            pace_sender();
        end

        for (int k = 0; k < RANDOM_NUMBERS; k++) begin
            steady = (k >= 300 && k < 400);
            send_number(pick_number());
            pace_sender();
        end
        steady = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        drain_wait = 0;
        while (pending_count != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        drain_done <= 1'b1;
        repeat (2) @(negedge i_clk);

        $display("checked %0d numbers: %0d split into odd prime pairs, %0d with no pair",
                 results_seen, pairs_seen, results_seen - pairs_seen);
        $display("sender ran in bursts, receiver stalled in open, coin, choked and periodic modes");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout: %0d numbers still pending", pending_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== goldbach_prime_pair_finder.f =====
src/gpf_pkg.sv
src/gpf_map.sv
src/gpf_front.sv
src/gpf_scan.sv
src/goldbach_prime_pair_finder.sv
verif/goldbach_pair_checker.sv
verif/goldbach_prime_pair_finder_tb.sv
